### src/wcp_pkg.sv
// Shared types and constants for the WAV container parser.
// No dependencies; imported by every module of the block but wcp_div.
`timescale 1ns / 1ps

package wcp_pkg;

  // Result kinds carried on tuser
  localparam logic [1:0] KIND_AUDIO = 2'd0;
  localparam logic [1:0] KIND_FMT   = 2'd1;
  localparam logic [1:0] KIND_SUM   = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  // Tags and chunk ids, first file byte in the lowest bits
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT   = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA  = 32'h6174_6164;

  localparam logic [15:0] PCM_CODE    = 16'd1;
  localparam logic [15:0] PCM_BITS    = 16'd16;
  localparam logic [31:0] FMT_MIN_LEN = 32'd16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic step;       // item accepted: advance the parser
    logic load_step;  // load the step result into the output register
    logic div_start;  // start the frame count division
    logic load_sum;   // load the end summary into the output register
  } wcp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic res_valid;  // this item gives a first result
    logic sum_need;   // this item closes the file with a summary
    logic div_done;   // frame count ready
  } wcp_sts_t;

endpackage

### src/wav_container_parser_unit.sv
// Top level of the WAV container parser: controller plus datapath.
// Depends on wcp_pkg, wcp_ctrl, wcp_dp (which holds wcp_div).
//
// Channel   Direction  tdata                         tuser            tlast
// in_       slave      [7:0] file_byte               -                end_of_file
// out_      master     [7:0] audio_byte,             [1:0] result_kind run_last
//                      [23:8] channel_count, [55:24] sample_rate,
//                      [87:56] data_length, [118:88] frame_count, [119] zero
//
// One byte is taken per cycle while no summary is pending and the output register is
// free or being emptied. A final byte that closes the file with a summary is followed by
// the bit-serial frame divider, a step to pass its done flag on and the summary load.
// Reset (synchronous, active low) returns the parser to the RIFF header; no clearing pass.
// A stalled output holds its item and stops input acceptance until it is taken.
`timescale 1ns / 1ps

module wav_container_parser_unit
  import wcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] file_byte
  input  logic         in_tlast,   // end_of_file
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // audio_byte, channel_count, sample_rate,
                                   // data_length, frame_count, zero pad
  output logic [1:0]   out_tuser,  // [1:0] result_kind
  output logic         out_tlast   // run_last
);

  wcp_cmd_t    cmd;
  wcp_sts_t    sts;
  logic [1:0]  kind;
  logic [7:0]  audio;
  logic [15:0] chans;
  logic [31:0] rate;
  logic [31:0] length;
  logic [30:0] frames;
  logic        last;

  wcp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  wcp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_byte      (in_tdata),
    .in_eof       (in_tlast),
    .sts          (sts),
    .out_kind     (kind),
    .out_audio    (audio),
    .out_channels (chans),
    .out_rate     (rate),
    .out_length   (length),
    .out_frames   (frames),
    .out_last     (last)
  );

  // Pack result fields, lowest field first
  assign out_tdata = {1'b0, frames, length, rate, chans, audio};
  assign out_tuser = kind;
  assign out_tlast = last;

endmodule

### src/wcp_div.sv
// Bit-serial restoring divider: length / (2 * channels), zero when channels is zero.
// Depends on nothing but itself; used by wcp_dp.
`timescale 1ns / 1ps

module wcp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] channels,
  output logic        done,
  output logic [30:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [16:0] dvs_r, dvs_nxt;
  logic [17:0] trial;
  logic [17:0] diff;

  // One quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[31]};
    diff     = trial - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = {channels, 1'b0};
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[16:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[16:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  // A zero divisor reports no frames
  assign quotient = (dvs_r == 17'd0) ? 31'd0 : quo_r[30:0];

endmodule

### src/wcp_dp.sv
// Parser datapath: header and chunk decoding, fmt fields, summary snapshot, output register.
// Depends on wcp_pkg and wcp_div; driven by commands from wcp_ctrl.
`timescale 1ns / 1ps

module wcp_dp
  import wcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  wcp_cmd_t     cmd,
  input  logic [7:0]   in_byte,
  input  logic         in_eof,
  output wcp_sts_t     sts,
  output logic [1:0]   out_kind,
  output logic [7:0]   out_audio,
  output logic [15:0]  out_channels,
  output logic [31:0]  out_rate,
  output logic [31:0]  out_length,
  output logic [30:0]  out_frames,
  output logic         out_last
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CHUNK  = 3'd1,
    PH_FMT    = 3'd2,
    PH_DATA   = 3'd3,
    PH_SKIP   = 3'd4,
    PH_DRAIN  = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic [31:0] chunk_id_r, chunk_id_nxt;
  logic [31:0] left_r, left_nxt;
  logic [4:0]  fmt_idx_r, fmt_idx_nxt;
  logic [15:0] format_r, format_nxt;
  logic [15:0] chans_r, chans_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [31:0] data_len_r, data_len_nxt;
  logic        err_r, err_nxt;

  // Summary snapshot and output register
  logic [15:0] sum_ch_r;
  logic [31:0] sum_rate_r;
  logic [31:0] sum_len_r;
  logic [1:0]  o_kind_r;
  logic [7:0]  o_audio_r;
  logic [15:0] o_ch_r;
  logic [31:0] o_rate_r;
  logic [31:0] o_len_r;
  logic [30:0] o_frames_r;
  logic        o_last_r;

  // Step result
  logic        res_v;
  logic [1:0]  res_kind;
  logic [7:0]  res_audio;
  logic [15:0] res_ch;
  logic [31:0] res_rate;
  logic        raise;
  logic        sum_need;
  logic        mismatch;
  logic [31:0] wide_b;
  logic        div_done;
  logic [30:0] div_q;

  assign wide_b = {24'd0, in_byte};

  // Advance the parser by one byte
  always_comb begin
    phase_nxt    = phase_r;
    hdr_idx_nxt  = hdr_idx_r;
    chunk_id_nxt = chunk_id_r;
    left_nxt     = left_r;
    fmt_idx_nxt  = fmt_idx_r;
    format_nxt   = format_r;
    chans_nxt    = chans_r;
    rate_nxt     = rate_r;
    bits_nxt     = bits_r;
    data_len_nxt = data_len_r;
    err_nxt      = err_r;
    res_v        = 1'b0;
    res_kind     = KIND_AUDIO;
    res_audio    = 8'd0;
    res_ch       = 16'd0;
    res_rate     = 32'd0;
    raise        = 1'b0;
    sum_need     = 1'b0;
    mismatch     = 1'b0;

    if (!err_r) begin
      case (phase_r)
        PH_HEADER: begin
          mismatch = (hdr_idx_r < 4'd4 &&
                      in_byte != TAG_RIFF[{hdr_idx_r[1:0], 3'b000} +: 8]) ||
                     (hdr_idx_r >= 4'd8 && hdr_idx_r < 4'd12 &&
                      in_byte != TAG_WAVE[{hdr_idx_r[1:0], 3'b000} +: 8]);
          if (mismatch) begin
            raise = 1'b1;
          end else if (hdr_idx_r >= 4'd11) begin
            phase_nxt   = PH_CHUNK;
            hdr_idx_nxt = 4'd0;
          end else begin
            hdr_idx_nxt = hdr_idx_r + 4'd1;
          end
        end
        PH_CHUNK: begin
          if (hdr_idx_r == 4'd0) begin
            chunk_id_nxt = wide_b;
          end else if (hdr_idx_r < 4'd4) begin
            chunk_id_nxt = chunk_id_r | (wide_b << {hdr_idx_r[1:0], 3'b000});
          end else if (hdr_idx_r == 4'd4) begin
            left_nxt = wide_b;
          end else begin
            left_nxt = left_r | (wide_b << {hdr_idx_r[1:0], 3'b000});
          end
          if (hdr_idx_r >= 4'd7) begin
            hdr_idx_nxt = 4'd0;
            if (chunk_id_nxt == ID_FMT) begin
              if (left_nxt < FMT_MIN_LEN) begin
                raise = 1'b1;
              end else begin
                phase_nxt   = PH_FMT;
                fmt_idx_nxt = 5'd0;
              end
            end else if (chunk_id_nxt == ID_DATA) begin
              data_len_nxt = left_nxt;
              phase_nxt    = (left_nxt != 32'd0) ? PH_DATA : PH_CHUNK;
            end else begin
              phase_nxt = (left_nxt != 32'd0) ? PH_SKIP : PH_CHUNK;
            end
          end else begin
            hdr_idx_nxt = hdr_idx_r + 4'd1;
          end
        end
        PH_FMT: begin
          left_nxt    = left_r - 32'd1;
          fmt_idx_nxt = fmt_idx_r + 5'd1;
          case (fmt_idx_r)
            5'd0:  format_nxt = {8'd0, in_byte};
            5'd1:  format_nxt = format_r | {in_byte, 8'd0};
            5'd2:  chans_nxt  = {8'd0, in_byte};
            5'd3:  chans_nxt  = chans_r | {in_byte, 8'd0};
            5'd4:  rate_nxt   = wide_b;
            5'd5, 5'd6, 5'd7:
              rate_nxt = rate_r | (wide_b << {fmt_idx_r[1:0], 3'b000});
            5'd14: bits_nxt   = {8'd0, in_byte};
            5'd15: bits_nxt   = bits_r | {in_byte, 8'd0};
            default: ;
          endcase
          if (fmt_idx_r >= 5'd15) begin
            if (format_nxt != PCM_CODE || bits_nxt != PCM_BITS) begin
              raise = 1'b1;
            end else begin
              res_v       = 1'b1;
              res_kind    = KIND_FMT;
              res_ch      = chans_nxt;
              res_rate    = rate_nxt;
              hdr_idx_nxt = 4'd0;
              phase_nxt   = (left_nxt != 32'd0) ? PH_SKIP : PH_CHUNK;
            end
          end
        end
        PH_DATA: begin
          res_v       = 1'b1;
          res_kind    = KIND_AUDIO;
          res_audio   = in_byte;
          left_nxt    = left_r - 32'd1;
          hdr_idx_nxt = 4'd0;
          phase_nxt   = (left_nxt != 32'd0) ? PH_DATA : PH_CHUNK;
        end
        PH_SKIP: begin
          left_nxt    = left_r - 32'd1;
          hdr_idx_nxt = 4'd0;
          phase_nxt   = (left_nxt != 32'd0) ? PH_SKIP : PH_CHUNK;
        end
        default: ;
      endcase
    end

    // File ending inside the header or the fmt fields is an error
    if (in_eof && !raise && !err_r) begin
      if (phase_nxt == PH_HEADER || phase_nxt == PH_FMT) begin
        raise = 1'b1;
      end else begin
        sum_need = 1'b1;
      end
    end

    if (raise) begin
      res_v     = 1'b1;
      res_kind  = KIND_ERR;
      res_audio = 8'd0;
      res_ch    = 16'd0;
      res_rate  = 32'd0;
      err_nxt   = 1'b1;
      phase_nxt = PH_DRAIN;
    end
  end

  // Hold parser state; the final byte returns it to reset
  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.step && in_eof)) begin
      phase_r    <= PH_HEADER;
      hdr_idx_r  <= '0;
      chunk_id_r <= '0;
      left_r     <= '0;
      fmt_idx_r  <= '0;
      format_r   <= '0;
      chans_r    <= '0;
      rate_r     <= '0;
      bits_r     <= '0;
      data_len_r <= '0;
      err_r      <= 1'b0;
    end else if (cmd.step) begin
      phase_r    <= phase_nxt;
      hdr_idx_r  <= hdr_idx_nxt;
      chunk_id_r <= chunk_id_nxt;
      left_r     <= left_nxt;
      fmt_idx_r  <= fmt_idx_nxt;
      format_r   <= format_nxt;
      chans_r    <= chans_nxt;
      rate_r     <= rate_nxt;
      bits_r     <= bits_nxt;
      data_len_r <= data_len_nxt;
      err_r      <= err_nxt;
    end
  end

  // Capture the summary values as they stand after the final byte
  always_ff @(posedge clk) begin
    if (cmd.step && sum_need) begin
      sum_ch_r   <= chans_nxt;
      sum_rate_r <= rate_nxt;
      sum_len_r  <= data_len_nxt;
    end
  end

  wcp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (data_len_nxt),
    .channels (chans_nxt),
    .done     (div_done),
    .quotient (div_q)
  );

  // Load the output register
  always_ff @(posedge clk) begin
    if (cmd.load_step) begin
      o_kind_r   <= res_kind;
      o_audio_r  <= res_audio;
      o_ch_r     <= res_ch;
      o_rate_r   <= res_rate;
      o_len_r    <= 32'd0;
      o_frames_r <= 31'd0;
      o_last_r   <= !sum_need;
    end else if (cmd.load_sum) begin
      o_kind_r   <= KIND_SUM;
      o_audio_r  <= 8'd0;
      o_ch_r     <= sum_ch_r;
      o_rate_r   <= sum_rate_r;
      o_len_r    <= sum_len_r;
      o_frames_r <= div_q;
      o_last_r   <= 1'b1;
    end
  end

  assign sts.res_valid = res_v;
  assign sts.sum_need  = sum_need;
  assign sts.div_done  = div_done;

  assign out_kind     = o_kind_r;
  assign out_audio    = o_audio_r;
  assign out_channels = o_ch_r;
  assign out_rate     = o_rate_r;
  assign out_length   = o_len_r;
  assign out_frames   = o_frames_r;
  assign out_last     = o_last_r;

endmodule

### src/wcp_ctrl.sv
// Controller: stream handshakes, output register occupancy, summary sequencing.
// Depends on wcp_pkg; issues commands to wcp_dp and reads its status.
`timescale 1ns / 1ps

module wcp_ctrl
  import wcp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  wcp_sts_t sts,
  output wcp_cmd_t cmd
);

  typedef enum logic [1:0] {
    C_RUN = 2'd0,
    C_DIV = 2'd1,
    C_SUM = 2'd2
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;
  logic        ready;

  // Sequence items, the division wait and the summary load
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    ready         = 1'b0;
    out_free      = !out_valid_r || out_tready;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      C_RUN: begin
        ready = out_free;
        if (in_tvalid && out_free) begin
          cmd.step = 1'b1;
          if (sts.res_valid) begin
            cmd.load_step = 1'b1;
            out_valid_nxt = 1'b1;
          end
          if (sts.sum_need) begin
            cmd.div_start = 1'b1;
            state_nxt     = C_DIV;
          end
        end
      end
      C_DIV: begin
        if (sts.div_done) begin
          state_nxt = C_SUM;
        end
      end
      C_SUM: begin
        if (out_free) begin
          cmd.load_sum  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = C_RUN;
        end
      end
      default: state_nxt = C_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= C_RUN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = ready;
  assign out_tvalid = out_valid_r;

endmodule
